>>> src/quaternion_to_euler_angles_core_defines.svh
// ============================================================================
// Assertion macros for quaternion_to_euler_angles_core
// Shorthand for clocked implication checks with asynchronous reset disable.
// ============================================================================
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define QTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/qte_pkg.sv
// ============================================================================
// qte_pkg
// Widths, constants, beat types and the arctangent table of the converter.
// ============================================================================
`timescale 1ns / 1ps

package qte_pkg;

	localparam int IN_W      = 16;
	localparam int ANGLE_W   = 16;
	localparam int QUAT_FRAC = 14;

	localparam int PROD_W    = 2 * IN_W;
	localparam int ARG_W     = PROD_W + 2;
	localparam int SF_W      = 32;
	localparam int UNIT_BITS = 30;
	localparam int SF_SHIFT  = UNIT_BITS - 2 * QUAT_FRAC;
	localparam int HALF_W    = 32;
	localparam int RAD_W     = 61;
	localparam int ROOT_W    = 31;

	localparam int NORM_BIT     = 40;
	localparam int NORM_W       = NORM_BIT + 2;
	localparam int NSH          = 6;
	localparam int CORDIC_STEPS = 31;
	localparam int CW           = 45;
	localparam int ZW           = 32;
	localparam int ATAN_LAT     = 1 + NSH + CORDIC_STEPS + 1;

	localparam int MID_DEPTH_DEF = 8;
	localparam int OUT_DEPTH_DEF = 2;

	localparam logic signed [ARG_W-1:0] S_ONE = ARG_W'(longint'(1) << (2 * QUAT_FRAC));
	localparam logic [HALF_W-1:0] UNIT = HALF_W'(longint'(1) << UNIT_BITS);

	localparam logic [ZW-1:0] Z_QUARTER  = 32'h4000_0000;
	localparam logic [ZW-1:0] Z_HALF     = 32'h8000_0000;
	localparam logic [ZW-1:0] Z_MQUARTER = 32'hC000_0000;

	localparam logic signed [ANGLE_W-1:0] QUARTER_ANGLE = ANGLE_W'(1 << (ANGLE_W - 2));

	typedef struct packed {
		logic signed [ARG_W-1:0] ry;
		logic signed [ARG_W-1:0] rx;
		logic signed [ARG_W-1:0] yy;
		logic signed [ARG_W-1:0] yx;
		logic signed [SF_W-1:0]  sf;
		logic                    clamped;
	} mid_item_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll;
		logic signed [ANGLE_W-1:0] pitch;
		logic signed [ANGLE_W-1:0] yaw;
		logic                      clamped;
	} res_item_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [ZW-1:0] atan_turn(input int unsigned i);
		logic [ZW-1:0] t;
		case (i)
			0:  t = 32'd536870912;
			1:  t = 32'd316933406;
			2:  t = 32'd167458907;
			3:  t = 32'd85004756;
			4:  t = 32'd42667331;
			5:  t = 32'd21354465;
			6:  t = 32'd10679838;
			7:  t = 32'd5340245;
			8:  t = 32'd2670163;
			9:  t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			24: t = 32'd41;
			25: t = 32'd20;
			26: t = 32'd10;
			27: t = 32'd5;
			28: t = 32'd3;
			29: t = 32'd1;
			30: t = 32'd1;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

>>> src/qte_fifo.sv
// ============================================================================
// qte_fifo
// Small first-word-fall-through queue of beats.
// ============================================================================
`timescale 1ns / 1ps

module qte_fifo #(
	parameter int DEPTH = 2,
	parameter type T = logic
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  T                             wdata,
	input  logic                         pop,
	output T                             rdata,
	output logic                         empty,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	T mem [0:DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [NW-1:0] cnt_q;
	logic do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == NW'(DEPTH));
	assign count   = cnt_q;
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + NW'(do_push) - NW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

endmodule

>>> src/qte_front.sv
// ============================================================================
// qte_front
// Input stage: products, quadratic forms and the pitch sine clamp.
// ============================================================================
`timescale 1ns / 1ps

module qte_front #(
	parameter int MID_DEPTH = qte_pkg::MID_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic signed [qte_pkg::IN_W-1:0]    q_scalar,
	input  logic signed [qte_pkg::IN_W-1:0]    q_x,
	input  logic signed [qte_pkg::IN_W-1:0]    q_y,
	input  logic signed [qte_pkg::IN_W-1:0]    q_z,
	input  logic [$clog2(MID_DEPTH+1)-1:0]     mid_count,
	output logic                               mid_push,
	output qte_pkg::mid_item_t                 mid_item
);
	import qte_pkg::*;

	localparam int CNT_W = $clog2(MID_DEPTH + 1);

	logic accept;
	logic v_s1, v_s2, v_s3;
	logic [CNT_W+1:0] in_flight;

	logic signed [IN_W-1:0] e0_s1, e1_s1, e2_s1, e3_s1;
	logic signed [PROD_W-1:0] p00_s2, p11_s2, p22_s2, p33_s2;
	logic signed [PROD_W-1:0] p01_s2, p23_s2, p03_s2, p12_s2, p02_s2, p13_s2;
	mid_item_t item_s3;

	logic signed [ARG_W-1:0] s_full, s_clamp;
	logic s_hi, s_lo;
	mid_item_t item_d;

	// credits: queue entries plus beats still in the three stages
	assign in_flight = (CNT_W+2)'(mid_count) + (CNT_W+2)'(v_s1)
		+ (CNT_W+2)'(v_s2) + (CNT_W+2)'(v_s3);
	assign full   = (in_flight >= (CNT_W+2)'(MID_DEPTH));
	assign accept = push & ~full;

	always_comb begin
		s_full  = (ARG_W'(p02_s2) - ARG_W'(p13_s2)) <<< 1;
		s_hi    = (s_full > S_ONE);
		s_lo    = (s_full < -S_ONE);
		s_clamp = s_hi ? S_ONE : (s_lo ? -S_ONE : s_full);
		item_d.ry = (ARG_W'(p01_s2) + ARG_W'(p23_s2)) <<< 1;
		item_d.rx = ARG_W'(p00_s2) + ARG_W'(p33_s2) - ARG_W'(p11_s2) - ARG_W'(p22_s2);
		item_d.yy = (ARG_W'(p03_s2) + ARG_W'(p12_s2)) <<< 1;
		item_d.yx = ARG_W'(p00_s2) + ARG_W'(p11_s2) - ARG_W'(p22_s2) - ARG_W'(p33_s2);
		item_d.sf = SF_W'(s_clamp <<< SF_SHIFT);
		item_d.clamped = s_hi | s_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e0_s1 <= q_scalar;
			e1_s1 <= q_x;
			e2_s1 <= q_y;
			e3_s1 <= q_z;
		end
		p00_s2 <= e0_s1 * e0_s1;
		p11_s2 <= e1_s1 * e1_s1;
		p22_s2 <= e2_s1 * e2_s1;
		p33_s2 <= e3_s1 * e3_s1;
		p01_s2 <= e0_s1 * e1_s1;
		p23_s2 <= e2_s1 * e3_s1;
		p03_s2 <= e0_s1 * e3_s1;
		p12_s2 <= e1_s1 * e2_s1;
		p02_s2 <= e0_s1 * e2_s1;
		p13_s2 <= e1_s1 * e3_s1;
		item_s3 <= item_d;
	end

	assign mid_push = v_s3;
	assign mid_item = item_s3;

endmodule

>>> src/qte_isqrt.sv
// ============================================================================
// qte_isqrt
// Pipelined floor square root, one result bit per stage, side beat carried.
// ============================================================================
`timescale 1ns / 1ps

module qte_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [qte_pkg::RAD_W-1:0]     radicand,
	input  qte_pkg::mid_item_t            in_side,
	output logic                          out_valid,
	output logic [qte_pkg::ROOT_W-1:0]    sq_root,
	output qte_pkg::mid_item_t            out_side
);
	import qte_pkg::*;

	localparam int TW = 2 * ROOT_W + 1;

	logic [RAD_W-1:0]  rem_q  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
	logic              v_q    [0:ROOT_W-1];
	mid_item_t         side_q [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		localparam int B = ROOT_W - 1 - k;
		logic [RAD_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		logic              v_i;
		mid_item_t         side_i;
		logic [TW-1:0]     trial;

		if (k == 0) begin : g_head
			assign rem_i  = radicand;
			assign root_i = '0;
			assign v_i    = in_valid;
			assign side_i = in_side;
		end else begin : g_tail
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign v_i    = v_q[k-1];
			assign side_i = side_q[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign trial = (TW'(root_i) << (B + 1)) + (TW'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (TW'(rem_i) >= trial) begin
					rem_q[k]  <= rem_i - RAD_W'(trial);
					root_q[k] <= root_i | (ROOT_W'(1) << B);
				end else begin
					rem_q[k]  <= rem_i;
					root_q[k] <= root_i;
				end
				side_q[k] <= side_i;
			end
		end
	end

	assign out_valid = v_q[ROOT_W-1];
	assign sq_root   = root_q[ROOT_W-1];
	assign out_side  = side_q[ROOT_W-1];

endmodule

>>> src/qte_atan.sv
// ============================================================================
// qte_atan
// Four-quadrant arctangent: range fold, staged normalize, vectoring CORDIC.
// ============================================================================
`timescale 1ns / 1ps

module qte_atan (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [qte_pkg::ARG_W-1:0]   y_in,
	input  logic signed [qte_pkg::ARG_W-1:0]   x_in,
	output logic signed [qte_pkg::ANGLE_W-1:0] angle
);
	import qte_pkg::*;

	logic signed [NORM_W-1:0] x0, y0;
	logic [NORM_W-1:0] ax0, ay0, m0;
	logic [ZW-1:0] z0;
	logic f0;

	logic signed [NORM_W-1:0] nx [0:NSH];
	logic signed [NORM_W-1:0] ny [0:NSH];
	logic [NORM_W-1:0]        nm [0:NSH];
	logic [ZW-1:0]            nz [0:NSH];
	logic                     nf [0:NSH];

	logic signed [CW-1:0] cx [0:CORDIC_STEPS-1];
	logic signed [CW-1:0] cy [0:CORDIC_STEPS-1];
	logic [ZW-1:0]        cz [0:CORDIC_STEPS-1];
	logic                 cf [0:CORDIC_STEPS-1];

	logic [ZW-1:0] z_rnd;

	// fold into the right half plane; a zero horizontal argument is final
	always_comb begin
		x0 = NORM_W'(x_in);
		y0 = NORM_W'(y_in);
		z0 = '0;
		f0 = 1'b0;
		if (x_in == '0) begin
			f0 = 1'b1;
			if (y_in > 0) begin
				z0 = Z_QUARTER;
			end else if (y_in < 0) begin
				z0 = Z_MQUARTER;
			end
		end else if (x_in < 0) begin
			x0 = -NORM_W'(x_in);
			y0 = -NORM_W'(y_in);
			z0 = Z_HALF;
		end
		ax0 = x0[NORM_W-1] ? -x0 : x0;
		ay0 = y0[NORM_W-1] ? -y0 : y0;
		m0  = ax0 | ay0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx[0] <= x0;
			ny[0] <= y0;
			nm[0] <= m0;
			nz[0] <= z0;
			nf[0] <= f0;
		end
	end

	// binary search for the left shift that lifts the larger magnitude to 2^40
	for (genvar j = 1; j <= NSH; j++) begin : g_norm
		localparam int S = 1 << (NSH - j);
		always_ff @(posedge clk) begin
			if (en) begin
				if ((nm[j-1] >> (NORM_BIT + 1 - S)) == '0) begin
					nx[j] <= nx[j-1] <<< S;
					ny[j] <= ny[j-1] <<< S;
					nm[j] <= nm[j-1] << S;
				end else begin
					nx[j] <= nx[j-1];
					ny[j] <= ny[j-1];
					nm[j] <= nm[j-1];
				end
				nz[j] <= nz[j-1];
				nf[j] <= nf[j-1];
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		logic signed [CW-1:0] xi, yi;
		logic [ZW-1:0] zi;
		logic fi;

		if (i == 0) begin : g_head
			assign xi = CW'(nx[NSH]);
			assign yi = CW'(ny[NSH]);
			assign zi = nz[NSH];
			assign fi = nf[NSH];
		end else begin : g_tail
			assign xi = cx[i-1];
			assign yi = cy[i-1];
			assign zi = cz[i-1];
			assign fi = cf[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[CW-1]) begin
					cx[i] <= xi + (yi >>> i);
					cy[i] <= yi - (xi >>> i);
					cz[i] <= fi ? zi : zi + atan_turn(i);
				end else begin
					cx[i] <= xi - (yi >>> i);
					cy[i] <= yi + (xi >>> i);
					cz[i] <= fi ? zi : zi - atan_turn(i);
				end
				cf[i] <= fi;
			end
		end
	end

	// round half up to the output angle width
	assign z_rnd = cz[CORDIC_STEPS-1] + (ZW'(1) << (ZW - 1 - ANGLE_W));

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= $signed(z_rnd[ZW-1 -: ANGLE_W]);
		end
	end

endmodule

>>> src/qte_back.sv
// ============================================================================
// qte_back
// Execution pipeline: pitch cosine by square root, three arctangent lanes.
// ============================================================================
`timescale 1ns / 1ps

module qte_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mid_empty,
	input  qte_pkg::mid_item_t   mid_item,
	output logic                 mid_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output qte_pkg::res_item_t   out_item
);
	import qte_pkg::*;

	logic adv;
	logic v_b0, v_b1;
	mid_item_t item_b0, item_b1;
	logic [HALF_W-1:0] um_b0, up_b0;
	logic [2*HALF_W-1:0] prod_full;
	logic [RAD_W-1:0] prod_b1;

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	mid_item_t sq_side;

	logic dv_q [0:ATAN_LAT-1];
	logic dc_q [0:ATAN_LAT-1];

	logic signed [ANGLE_W-1:0] roll_z, pitch_z, yaw_z;

	// whole pipeline moves together; it holds only when a finished beat is blocked
	assign adv     = ~(dv_q[ATAN_LAT-1] & out_full);
	assign mid_pop = adv & ~mid_empty;

	assign prod_full = um_b0 * up_b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b0 <= 1'b0;
			v_b1 <= 1'b0;
			for (int k = 0; k < ATAN_LAT; k++) begin
				dv_q[k] <= 1'b0;
			end
		end else if (adv) begin
			v_b0 <= mid_pop;
			v_b1 <= v_b0;
			dv_q[0] <= sq_valid;
			for (int k = 1; k < ATAN_LAT; k++) begin
				dv_q[k] <= dv_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_b0 <= mid_item;
			um_b0   <= UNIT - $unsigned(mid_item.sf);
			up_b0   <= UNIT + $unsigned(mid_item.sf);
			item_b1 <= item_b0;
			prod_b1 <= prod_full[RAD_W-1:0];
			dc_q[0] <= sq_side.clamped;
			for (int k = 1; k < ATAN_LAT; k++) begin
				dc_q[k] <= dc_q[k-1];
			end
		end
	end

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_b1),
		.radicand  (prod_b1),
		.in_side   (item_b1),
		.out_valid (sq_valid),
		.sq_root   (sq_root),
		.out_side  (sq_side)
	);

	qte_atan u_roll (
		.clk   (clk),
		.en    (adv),
		.y_in  (sq_side.ry),
		.x_in  (sq_side.rx),
		.angle (roll_z)
	);

	qte_atan u_pitch (
		.clk   (clk),
		.en    (adv),
		.y_in  (ARG_W'(sq_side.sf)),
		.x_in  ($signed(ARG_W'(sq_root))),
		.angle (pitch_z)
	);

	qte_atan u_yaw (
		.clk   (clk),
		.en    (adv),
		.y_in  (sq_side.yy),
		.x_in  (sq_side.yx),
		.angle (yaw_z)
	);

	assign out_push         = adv & dv_q[ATAN_LAT-1];
	assign out_item.roll    = roll_z;
	assign out_item.pitch   = pitch_z;
	assign out_item.yaw     = yaw_z;
	assign out_item.clamped = dc_q[ATAN_LAT-1];

endmodule

>>> src/quaternion_to_euler_angles_core.sv
// ============================================================================
// quaternion_to_euler_angles_core
// Attitude quaternion (scalar first, Q1.14) to ZYX roll, pitch, yaw angles.
// ============================================================================
//
//   channel  | handshake            | beat
//   ---------+----------------------+------------------------------------------
//   input    | push / full          | q_scalar, q_x, q_y, q_z
//   result   | pop / empty          | roll_angle, pitch_angle, yaw_angle,
//            |                      | pitch_clamped
//
// Takes one quaternion per cycle while full is low and returns one result
// per quaternion. The beat passes 77 registers: 3 front stages (the first
// loads at the accepting edge), the mid queue, 2 stages for the pitch cosine
// product, 31 square-root stages, 39 arctangent stages (fold, six normalize
// steps, 31 CORDIC steps, round) and the result queue.
// Reset clears only valid bits and queue pointers; no clearing pass.
// A blocked result stalls the back pipeline; the front keeps filling the mid
// queue until its credits run out, then full goes high.
//
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_core_defines.svh"

module quaternion_to_euler_angles_core #(
	parameter int MID_DEPTH = qte_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = qte_pkg::OUT_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [qte_pkg::IN_W-1:0]       q_scalar,
	input  logic signed [qte_pkg::IN_W-1:0]       q_x,
	input  logic signed [qte_pkg::IN_W-1:0]       q_y,
	input  logic signed [qte_pkg::IN_W-1:0]       q_z,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [qte_pkg::ANGLE_W-1:0]    roll_angle,
	output logic signed [qte_pkg::ANGLE_W-1:0]    pitch_angle,
	output logic signed [qte_pkg::ANGLE_W-1:0]    yaw_angle,
	output logic                                  pitch_clamped
);
	import qte_pkg::*;

	localparam int MID_CW = $clog2(MID_DEPTH + 1);

	// front -> mid queue
	logic        mid_push;
	mid_item_t   mid_wdata;
	logic [MID_CW-1:0] mid_count;

	// mid queue -> back
	logic        mid_pop;
	logic        mid_empty;
	mid_item_t   mid_rdata;

	// back -> result queue
	logic        out_push;
	logic        out_full;
	res_item_t   out_wdata;
	res_item_t   out_rdata;

	// quadratic forms and the clamped pitch sine
	qte_front #(
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.q_scalar  (q_scalar),
		.q_x       (q_x),
		.q_y       (q_y),
		.q_z       (q_z),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_item  (mid_wdata)
	);

	// decouples the free-running front from the stallable back
	qte_fifo #(
		.DEPTH (MID_DEPTH),
		.T     (mid_item_t)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.full   (),
		.count  (mid_count)
	);

	qte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (mid_rdata),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_wdata)
	);

	// result skid queue: lets the back keep moving while a result waits
	qte_fifo #(
		.DEPTH (OUT_DEPTH),
		.T     (res_item_t)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wdata),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.full   (out_full),
		.count  ()
	);

	assign roll_angle    = out_rdata.roll;
	assign pitch_angle   = out_rdata.pitch;
	assign yaw_angle     = out_rdata.yaw;
	assign pitch_clamped = out_rdata.clamped;

	// credit accounting must never let the front overrun the mid queue
	`QTE_ASSERT_NOW(a_mid_credit, clk, arst_n, mid_push, mid_count < MID_CW'(MID_DEPTH), "mid queue overrun")

	// the back must hold a finished beat while the result queue is full
	`QTE_ASSERT_NOW(a_out_no_drop, clk, arst_n, out_push, !out_full, "result dropped into full queue")

	// a clamped sine always yields a pitch of exactly plus or minus a quarter turn
	`QTE_ASSERT_NOW(a_clamp_quarter, clk, arst_n, !empty && pitch_clamped, pitch_angle == QUARTER_ANGLE || pitch_angle == -QUARTER_ANGLE, "clamped pitch not at quarter turn")

endmodule

>>> tb/sv/quaternion_to_euler_angles_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// quaternion_to_euler_angles_checker
// Watches both queue channels, predicts Euler angles for every accepted
// quaternion beat and compares them in order with the popped result beats.
// ============================================================================

module quaternion_to_euler_angles_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic                                full,
	input  logic signed [qte_pkg::IN_W-1:0]     q_scalar,
	input  logic signed [qte_pkg::IN_W-1:0]     q_x,
	input  logic signed [qte_pkg::IN_W-1:0]     q_y,
	input  logic signed [qte_pkg::IN_W-1:0]     q_z,
	input  logic                                empty,
	input  logic                                pop,
	input  logic signed [qte_pkg::ANGLE_W-1:0]  roll_angle,
	input  logic signed [qte_pkg::ANGLE_W-1:0]  pitch_angle,
	input  logic signed [qte_pkg::ANGLE_W-1:0]  yaw_angle,
	input  logic                                pitch_clamped,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  done_count,
	output int                                  clamp_count
);
	import qte_pkg::*;

	res_item_t angles_q[$];

	localparam longint LIMIT40 = longint'(1) << 40;

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint absl(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [31:0] atan_table(int i);
		logic [31:0] t[31] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
			20, 10, 5, 3, 1, 1};
		return t[i];
	endfunction

	// vectoring CORDIC, result in 2^-32 turn
	function automatic logic [31:0] turn_of(longint y, longint x);
		logic [31:0] z;
		longint nx;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x == 0) return y > 0 ? 32'h4000_0000 : 32'hC000_0000;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		while (absl(x) < LIMIT40 && absl(y) < LIMIT40) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 31; i++) begin
			if (y >= 0) begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z = z + atan_table(i);
			end else begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z = z - atan_table(i);
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic logic [15:0] round_angle(logic [31:0] z);
		logic [32:0] r;
		r = ({1'b0, z} + 33'h8000) >> 16;
		return r[15:0];
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic res_item_t euler_of(longint e0, longint e1, longint e2, longint e3);
		res_item_t r;
		longint one, s, sf, unit_v, c;
		one = longint'(1) << 28;
		unit_v = longint'(1) << 30;
		r.clamped = 1'b0;
		s = 2 * (e0 * e2 - e1 * e3);
		if (s > one) begin
			s = one;
			r.clamped = 1'b1;
		end
		if (s < -one) begin
			s = -one;
			r.clamped = 1'b1;
		end
		sf = s * 4;
		c = int_sqrt(longint'(unit_v - sf) * longint'(unit_v + sf));
		r.roll  = round_angle(turn_of(2 * (e0 * e1 + e2 * e3),
			e0 * e0 + e3 * e3 - e1 * e1 - e2 * e2));
		r.pitch = round_angle(turn_of(sf, c));
		r.yaw   = round_angle(turn_of(2 * (e0 * e3 + e1 * e2),
			e0 * e0 + e1 * e1 - e2 * e2 - e3 * e3));
		return r;
	endfunction

	assign pending = angles_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_item_t want;
		if (!arst_n) begin
			fail_count <= 0;
			done_count <= 0;
			clamp_count <= 0;
		end else begin
			if (push && !full)
				angles_q.insert(angles_q.size(), euler_of(q_scalar, q_x, q_y, q_z));
			if (pop && !empty) begin
				done_count <= done_count + 1;
				if (pitch_clamped)
					clamp_count <= clamp_count + 1;
				if (angles_q.size() == 0) begin
					$display("%t: result beat with nothing expected", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					want = angles_q.pop_front();
					if (want.roll !== roll_angle || want.pitch !== pitch_angle ||
							want.yaw !== yaw_angle || want.clamped !== pitch_clamped) begin
						$display("%t: mismatch expected r=%0d p=%0d y=%0d c=%0d actual r=%0d p=%0d y=%0d c=%0d",
							$realtime, want.roll, want.pitch, want.yaw, want.clamped,
							roll_angle, pitch_angle, yaw_angle, pitch_clamped);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/quaternion_to_euler_angles_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// quaternion_to_euler_angles_core_test
// Drives quaternion beats into the converter with random gaps and result
// back-pressure, including one long hold-off; the checker does the scoring.
// ============================================================================

module quaternion_to_euler_angles_core_test;
	import qte_pkg::*;

	localparam int N_RANDOM   = 430;
	localparam int LATENCY    = 77;
	localparam int CYCLE_CAP  = 200000;
	localparam int HOLD_LEN   = 300;

	logic clk, arst_n, push, full, empty, pop, pitch_clamped;
	logic signed [IN_W-1:0] q_scalar, q_x, q_y, q_z;
	logic signed [ANGLE_W-1:0] roll_angle, pitch_angle, yaw_angle;
	int fail_count, pending, done_count, clamp_count;
	int cycles;
	bit quiet;      // no idling in the final stretch
	bit hold_req;   // receiver holds off
	bit hold_done;

	quaternion_to_euler_angles_core dut (.*);

	quaternion_to_euler_angles_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: random pop bursts, plus one long hold-off counted here
	initial begin
		int n;
		pop = 0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				pop <= 0;
				for (int i = 0; i < HOLD_LEN; i++) @(negedge clk);
				hold_done = 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop <= 0;
				n = $urandom_range(1, 4);
				repeat (n - 1) @(negedge clk);
			end else begin
				pop <= 1;
			end
		end
	end

	// one beat: hold push until the block takes it
	task automatic send_quat(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 0;
			n = $urandom_range(1, 4);
			repeat (n) @(negedge clk);
		end
		push <= 1;
		q_scalar <= a;
		q_x <= b;
		q_y <= c;
		q_z <= d;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'($urandom);               // any code, incl. out of range
			1: return 16'sd16384;
			2: return -16'sd16384;
			3: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom_range(0, 32768)) - 16'd16384;
		endcase
	endfunction

	initial begin
		logic [15:0] a, b, c, d;
		real fa, fb, fc, fd, nrm;
		push = 0;
		q_scalar = 0;
		q_x = 0;
		q_y = 0;
		q_z = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: identity, axes, zero, extremes, gimbal lock, clamp both ways
		send_quat(16384, 0, 0, 0);
		send_quat(0, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);
		send_quat(0, 0, 16384, 0);
		send_quat(0, 0, 0, 16384);
		send_quat(0, -16384, 0, 0);
		send_quat(0, 0, -16384, 0);
		send_quat(0, 0, 0, -16384);
		send_quat(11585, 0, 11585, 0);
		send_quat(11585, 0, -11585, 0);
		send_quat(16384, 0, 16384, 0);
		send_quat(16384, 0, -16384, 0);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(-32768, 32767, -32768, 32767);
		send_quat(11585, 11585, 0, 0);
		send_quat(0, 0, 11585, 11585);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(1, 0, 0, 0);
		send_quat(0, 1, 0, 0);
		send_quat(-1, 0, 0, -1);
		send_quat(8192, 8192, 8192, 8192);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == 60) hold_req = 1;
			if (k == N_RANDOM - 60) quiet = 1;
			if ($urandom_range(0, 3) != 0) begin
				// mostly unit quaternions with random orientation
				fa = $itor($signed(16'($urandom))); fb = $itor($signed(16'($urandom)));
				fc = $itor($signed(16'($urandom))); fd = $itor($signed(16'($urandom)));
				nrm = $sqrt(fa * fa + fb * fb + fc * fc + fd * fd) + 1.0;
				a = 16'($rtoi(fa * 16384.0 / nrm));
				b = 16'($rtoi(fb * 16384.0 / nrm));
				c = 16'($rtoi(fc * 16384.0 / nrm));
				d = 16'($rtoi(fd * 16384.0 / nrm));
			end else begin
				a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
			end
			send_quat(a, b, c, d);
		end
		push <= 0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Converted %0d quaternions, %0d with clamped pitch, under random stalls.",
			done_count, clamp_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> quaternion_to_euler_angles_core.f
+incdir+src
src/qte_pkg.sv
src/qte_fifo.sv
src/qte_front.sv
src/qte_isqrt.sv
src/qte_atan.sv
src/qte_back.sv
src/quaternion_to_euler_angles_core.sv
tb/sv/quaternion_to_euler_angles_checker.sv
tb/sv/quaternion_to_euler_angles_core_test.sv
